FILE: hdl/upta_pkg.sv
// Shared types and constants for the UDP port table allocator.
// No dependencies; the top level and its tests reference it by scoped names.
package upta_pkg;

    localparam int PORT_COUNT_DEF = 65536;
    localparam int MAX_OWNERS_DEF = 256;
    localparam int WORD_BITS      = 32;

    localparam logic [15:0] RANGE_FIRST_RST = 16'd50000;
    localparam logic [16:0] RANGE_END_RST   = 17'd60000;

    // Configuration register indexes.
    localparam logic CFG_RANGE_FIRST = 1'b0;
    localparam logic CFG_RANGE_END   = 1'b1;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_LOOKUP  = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_IN_USE    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_MISS      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RESP
    } t_state;

endpackage

FILE: hdl/upta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the port bitmap and the owner table.
module upta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/udp_port_table_allocator.sv
// Bind, release and lookup pass a check state between accept and result; the unused code,
// port zero on release, ports beyond the table and an empty ephemeral range skip it.
// An ephemeral allocation scans bitmap words (32 ports each) until a free port or the last word.
// One item at a time; the next request is accepted the cycle after the result is
// registered, so an item holds the block until then. Reset: synchronous, active low; a
// clearing pass then zeroes every bitmap word (PORT_COUNT/32 words, 2048 by default).
module udp_port_table_allocator #(
    parameter int PORT_COUNT = upta_pkg::PORT_COUNT_DEF,
    parameter int MAX_OWNERS = upta_pkg::MAX_OWNERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_port,
    input  logic [7:0]  i_owner_id,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_port_out,
    output logic [7:0]  o_owner_out,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    // The taken flags live in a bitmap of 32-bit words so that an ephemeral
    // scan examines 32 ports per memory read. Owners live in a separate table
    // indexed by port; an owner is only reported for a port whose flag is set.
    localparam int WB    = upta_pkg::WORD_BITS;
    localparam int WORDS = (PORT_COUNT + WB - 1) / WB;
    localparam int WW    = $clog2(WORDS);
    localparam int PW    = $clog2(PORT_COUNT);
    localparam logic [WW-1:0] LAST_WORD = WW'(WORDS - 1);
    localparam logic [16:0]   PORT_LIM  = 17'(PORT_COUNT);

    // Owner modulo table, worked out at elaboration.
    logic [7:0] own_mod [256];
    for (genvar g = 0; g < 256; g++) begin : g_own_mod
        assign own_mod[g] = 8'(g % MAX_OWNERS);
    end

    // Returns the index of the lowest set bit of a word.
    function automatic logic [4:0] f_first(input logic [WB-1:0] v);
        logic [WB-1:0] low;
        logic [4:0]    idx;
        low = v & (~v + WB'(1));
        idx = '0;
        for (int b = 0; b < WB; b++) begin
            if (low[b]) begin
                idx = idx | 5'(b);
            end
        end
        return idx;
    endfunction

    upta_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_range_first;
    logic [16:0] r_range_end;

    // Clearing sweep counter.
    logic [WW-1:0] r_clr;

    // Captured request.
    upta_pkg::t_func r_func;
    logic [15:0]     r_port;
    logic [7:0]      r_owner;

    // Scan bounds and cursor.
    logic [WW-1:0] r_word, r_lo_word, r_hi_word;
    logic [4:0]    r_lo_bit, r_hi_bit;

    // Pending result, waiting for the output register.
    upta_pkg::t_status r_res_status, n_res_status;
    logic [15:0]       r_res_port, n_res_port;
    logic [7:0]        r_res_owner, n_res_owner;

    // Output register.
    logic              r_o_valid;
    upta_pkg::t_status r_o_status;
    logic [15:0]       r_o_port;
    logic [7:0]        r_o_owner;

    // Memory controls.
    logic          bm_we;
    logic [WW-1:0] bm_waddr, bm_raddr;
    logic [WB-1:0] bm_wdata, bm_rdata;
    logic          own_we;
    logic [PW-1:0] own_waddr, own_raddr;
    logic [7:0]    own_wdata, own_rdata;

    upta_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    upta_ram #(.WIDTH(8), .DEPTH(PORT_COUNT)) u_owner (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    // Request decode on the accepting beat.
    logic            in_accept;
    upta_pkg::t_func in_func;
    logic            in_port_zero, in_port_oob;
    assign in_accept    = i_valid && o_ready;
    assign in_func      = upta_pkg::t_func'(i_func);
    assign in_port_zero = (i_port == 16'd0);
    assign in_port_oob  = ({1'b0, i_port} >= PORT_LIM);

    // Ephemeral scan window: max(range_first, 1) up to min(range_end, PORT_COUNT).
    logic [16:0] scan_lo, scan_hi, scan_last;
    logic        scan_empty;
    assign scan_lo    = (r_range_first == 16'd0) ? 17'd1 : {1'b0, r_range_first};
    assign scan_hi    = (r_range_end < PORT_LIM) ? r_range_end : PORT_LIM;
    assign scan_last  = scan_hi - 17'd1;
    assign scan_empty = (scan_lo >= scan_hi);

    // Checks on the word returned by the bitmap.
    logic          chk_taken;
    logic [WB-1:0] lo_mask, hi_mask, scan_free;
    logic          scan_hit;
    logic [4:0]    scan_bit;
    logic [15:0]   scan_port;
    assign chk_taken = bm_rdata[r_port[4:0]];
    assign lo_mask   = (r_word == r_lo_word) ? ({WB{1'b1}} << r_lo_bit) : {WB{1'b1}};
    assign hi_mask   = (r_word == r_hi_word) ? ({WB{1'b1}} >> (5'd31 - r_hi_bit)) : {WB{1'b1}};
    assign scan_free = ~bm_rdata & lo_mask & hi_mask;
    assign scan_hit  = |scan_free;
    assign scan_bit  = f_first(scan_free);
    assign scan_port = 16'({r_word, scan_bit});

    logic out_free;
    assign out_free = !r_o_valid || i_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            upta_pkg::S_CLEAR: begin
                if (r_clr == LAST_WORD) n_state = upta_pkg::S_IDLE;
            end
            upta_pkg::S_IDLE: begin
                if (in_accept) begin
                    unique case (in_func)
                        upta_pkg::FN_ALLOC: begin
                            if (in_port_zero) begin
                                n_state = scan_empty ? upta_pkg::S_RESP : upta_pkg::S_SCAN_RD;
                            end else begin
                                n_state = in_port_oob ? upta_pkg::S_RESP : upta_pkg::S_CHK;
                            end
                        end
                        upta_pkg::FN_RELEASE: begin
                            n_state = (in_port_zero || in_port_oob) ? upta_pkg::S_RESP
                                                                    : upta_pkg::S_CHK;
                        end
                        upta_pkg::FN_LOOKUP: begin
                            n_state = in_port_oob ? upta_pkg::S_RESP : upta_pkg::S_CHK;
                        end
                        default: n_state = upta_pkg::S_RESP;
                    endcase
                end
            end
            upta_pkg::S_CHK:     n_state = upta_pkg::S_RESP;
            upta_pkg::S_SCAN_RD: n_state = upta_pkg::S_SCAN_CHK;
            upta_pkg::S_SCAN_CHK: begin
                if (scan_hit || r_word == r_hi_word) n_state = upta_pkg::S_RESP;
                else                                 n_state = upta_pkg::S_SCAN_RD;
            end
            upta_pkg::S_RESP: begin
                if (out_free) n_state = upta_pkg::S_IDLE;
            end
            default: n_state = upta_pkg::S_CLEAR;
        endcase
    end

    // Outputs of the sequencer: handshake, memory controls and the pending result.
    always_comb begin
        o_ready      = 1'b0;
        bm_we        = 1'b0;
        bm_waddr     = WW'(r_port >> 5);
        bm_wdata     = bm_rdata;
        bm_raddr     = WW'(i_port >> 5);
        own_we       = 1'b0;
        own_waddr    = PW'(r_port);
        own_wdata    = r_owner;
        own_raddr    = PW'(i_port);
        n_res_status = r_res_status;
        n_res_port   = r_res_port;
        n_res_owner  = r_res_owner;
        unique case (r_state)
            upta_pkg::S_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = r_clr;
                bm_wdata = '0;
            end
            upta_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                // Defaults cover the requests that finish without a table access.
                n_res_port  = i_port;
                n_res_owner = 8'd0;
                unique case (in_func)
                    upta_pkg::FN_ALLOC: begin
                        if (in_port_zero) begin
                            n_res_status = upta_pkg::ST_EXHAUSTED;
                            n_res_port   = 16'd0;
                        end else begin
                            n_res_status = upta_pkg::ST_IN_USE;
                        end
                    end
                    upta_pkg::FN_LOOKUP: n_res_status = upta_pkg::ST_MISS;
                    default:             n_res_status = upta_pkg::ST_OK;
                endcase
            end
            upta_pkg::S_CHK: begin
                n_res_port  = r_port;
                n_res_owner = 8'd0;
                unique case (r_func)
                    upta_pkg::FN_ALLOC: begin
                        if (chk_taken) begin
                            n_res_status = upta_pkg::ST_IN_USE;
                        end else begin
                            n_res_status = upta_pkg::ST_OK;
                            bm_we        = 1'b1;
                            bm_wdata     = bm_rdata | (WB'(1) << r_port[4:0]);
                            own_we       = 1'b1;
                        end
                    end
                    upta_pkg::FN_RELEASE: begin
                        n_res_status = upta_pkg::ST_OK;
                        bm_we        = 1'b1;
                        bm_wdata     = bm_rdata & ~(WB'(1) << r_port[4:0]);
                    end
                    upta_pkg::FN_LOOKUP: begin
                        if (chk_taken) begin
                            n_res_status = upta_pkg::ST_OK;
                            n_res_owner  = own_rdata;
                        end else begin
                            n_res_status = upta_pkg::ST_MISS;
                        end
                    end
                    default: n_res_status = upta_pkg::ST_OK;
                endcase
            end
            upta_pkg::S_SCAN_RD: begin
                bm_raddr = r_word;
            end
            upta_pkg::S_SCAN_CHK: begin
                bm_raddr    = r_word;
                n_res_owner = 8'd0;
                if (scan_hit) begin
                    n_res_status = upta_pkg::ST_OK;
                    n_res_port   = scan_port;
                    bm_we        = 1'b1;
                    bm_waddr     = r_word;
                    bm_wdata     = bm_rdata | (WB'(1) << scan_bit);
                    own_we       = 1'b1;
                    own_waddr    = PW'(scan_port);
                end else begin
                    n_res_status = upta_pkg::ST_EXHAUSTED;
                    n_res_port   = 16'd0;
                end
            end
            upta_pkg::S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= upta_pkg::S_CLEAR;
            r_clr         <= '0;
            r_o_valid     <= 1'b0;
            r_range_first <= upta_pkg::RANGE_FIRST_RST;
            r_range_end   <= upta_pkg::RANGE_END_RST;
        end else begin
            r_state <= n_state;
            if (r_state == upta_pkg::S_CLEAR) begin
                r_clr <= r_clr + WW'(1);
            end
            if (r_state == upta_pkg::S_RESP && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == upta_pkg::CFG_RANGE_FIRST) begin
                    r_range_first <= i_cfg_data[15:0];
                end else begin
                    r_range_end <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_port   <= n_res_port;
        r_res_owner  <= n_res_owner;
        if (in_accept) begin
            r_func    <= in_func;
            r_port    <= i_port;
            r_owner   <= own_mod[i_owner_id];
            r_word    <= WW'(scan_lo >> 5);
            r_lo_word <= WW'(scan_lo >> 5);
            r_hi_word <= WW'(scan_last >> 5);
            r_lo_bit  <= scan_lo[4:0];
            r_hi_bit  <= scan_last[4:0];
        end else if (r_state == upta_pkg::S_SCAN_CHK) begin
            r_word <= r_word + WW'(1);
        end
        if (r_state == upta_pkg::S_RESP && out_free) begin
            r_o_status <= r_res_status;
            r_o_port   <= r_res_port;
            r_o_owner  <= r_res_owner;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_port_out  = r_o_port;
    assign o_owner_out = r_o_owner;

`ifndef SYNTHESIS
    // One item at a time: the beat after an accept never accepts again.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while a request was in flight");

    // The scan cursor stays inside the window it was started with.
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == upta_pkg::S_SCAN_CHK) |-> (r_word >= r_lo_word && r_word <= r_hi_word))
        else $error("scan cursor left the ephemeral window");

    // An owner is reported only with a successful status.
    a_owner_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_owner_out != 8'd0) |-> (o_status == upta_pkg::ST_OK))
        else $error("owner reported on a failed request");

    // An exhausted range reports port zero.
    a_exhausted_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == upta_pkg::ST_EXHAUSTED) |-> (o_port_out == 16'd0))
        else $error("exhausted result carries a port");

    // The bitmap is only written while clearing or when a word check completes.
    a_bitmap_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bm_we |-> (r_state == upta_pkg::S_CLEAR || r_state == upta_pkg::S_CHK
                   || r_state == upta_pkg::S_SCAN_CHK))
        else $error("unexpected bitmap write");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for udp_port_table_allocator: binds, ephemeral allocations,
// releases and lookups against an in-bench copy of the port table.
// Depends only on upta_pkg and the allocator top level.
module tb_top;

    // The slowest realistic run is about 430 beats. The worst is an ephemeral scan
    // across the full table (2048 words). Add the longest sender gap, the longest
    // receiver stall, the clearing pass and the hold-off, and the total is still
    // well under the limit.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        upta_pkg::t_status status;
        logic [15:0]       port;
        logic [7:0]        owner;
    } t_port_result;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    upta_pkg::t_func req_func  = upta_pkg::FN_ALLOC;
    logic [15:0]     req_port  = '0;
    logic [7:0]      req_owner = '0;
    logic            rsp_ready = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_index = upta_pkg::CFG_RANGE_FIRST;
    logic [16:0]     cfg_data  = '0;

    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_port_out;
    logic [7:0]  o_owner_out;
    logic        o_cfg_ready;

    udp_port_table_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_ready     (o_ready),
        .i_func      (req_func),
        .i_port      (req_port),
        .i_owner_id  (req_owner),
        .o_valid     (o_valid),
        .i_ready     (rsp_ready),
        .o_status    (o_status),
        .o_port_out  (o_port_out),
        .o_owner_out (o_owner_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Bench copy of the port table and the range registers.
    bit          tbl_taken [upta_pkg::PORT_COUNT_DEF];
    logic [7:0]  tbl_owner [upta_pkg::PORT_COUNT_DEF];
    logic [15:0] rng_first = upta_pkg::RANGE_FIRST_RST;
    logic [16:0] rng_end   = upta_pkg::RANGE_END_RST;

    t_port_result pending_results[$];
    logic [15:0]  bound_ports[$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   rx_stall    = 0;
    bit   quiet       = 1'b0;
    logic rx_hold     = 1'b0;
    event hold_go;

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Applies one request to the bench table and returns the result it must produce.
    // A 16-bit port can never reach past the 65536-entry table, so that case drops out.
    function automatic t_port_result table_predict(upta_pkg::t_func fn, logic [15:0] port,
                                                   logic [7:0] oid);
        t_port_result r;
        int           lo;
        int           hi;
        int           p;
        bit           found;
        r.status = upta_pkg::ST_OK;
        r.port   = port;
        r.owner  = '0;
        case (fn)
            upta_pkg::FN_ALLOC: begin
                if (port == 16'd0) begin
                    // Ephemeral request: first free port of the clamped range.
                    lo    = (rng_first < 1) ? 1 : int'(rng_first);
                    hi    = (rng_end < upta_pkg::PORT_COUNT_DEF) ? int'(rng_end)
                                                                  : upta_pkg::PORT_COUNT_DEF;
                    found = 1'b0;
                    p     = lo;
                    while (!found && p < hi) begin
                        if (!tbl_taken[p]) begin
                            found = 1'b1;
                        end else begin
                            p++;
                        end
                    end
                    if (found) begin
                        tbl_taken[p] = 1'b1;
                        tbl_owner[p] = 8'(oid % upta_pkg::MAX_OWNERS_DEF);
                        r.port       = p[15:0];
                    end else begin
                        r.status = upta_pkg::ST_EXHAUSTED;
                        r.port   = '0;
                    end
                end else if (tbl_taken[port]) begin
                    r.status = upta_pkg::ST_IN_USE;
                end else begin
                    tbl_taken[port] = 1'b1;
                    tbl_owner[port] = 8'(oid % upta_pkg::MAX_OWNERS_DEF);
                end
            end
            upta_pkg::FN_RELEASE: begin
                // Port zero is never bound, so releasing it changes nothing.
                if (port != 16'd0)
                    tbl_taken[port] = 1'b0;
            end
            upta_pkg::FN_LOOKUP: begin
                if (tbl_taken[port]) begin
                    r.owner = tbl_owner[port];
                end else begin
                    r.status = upta_pkg::ST_MISS;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one request beat and records its expected result at the accepting edge.
    // Valid stays high after the beat, so a following call with no gap keeps the
    // channel busy without a low cycle in between.
    task automatic send_request(upta_pkg::t_func fn, logic [15:0] port, logic [7:0] oid);
        int           gap;
        t_port_result want;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= fn;
        req_port  <= port;
        req_owner <= oid;
        @(posedge clk);
        while (!o_ready) @(posedge clk);
        want = table_predict(fn, port, oid);
        pending_results.push_back(want);
        if (fn == upta_pkg::FN_ALLOC && want.status == upta_pkg::ST_OK) begin
            bound_ports.push_back(want.port);
            if (bound_ports.size() > 32)
                void'(bound_ports.pop_front());
        end
    endtask

    // Lowers the request valid and waits until every expected result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Writes both range registers back to back; valid stays high between the beats.
    task automatic program_range(logic [15:0] first, logic [16:0] last_end);
        cfg_valid <= 1'b1;
        cfg_index <= upta_pkg::CFG_RANGE_FIRST;
        cfg_data  <= {1'b0, first};
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_index <= upta_pkg::CFG_RANGE_END;
        cfg_data  <= last_end;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        rng_first = first;
        rng_end   = last_end;
    endtask

    // Port choice favors the ephemeral range and ports already bound, so binds,
    // lookups and releases hit live entries. Fully random ports toggle every bit.
    function automatic logic [15:0] pick_port();
        logic [16:0] near;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            near = 17'(rng_first + $urandom_range(0, 40));
            return near[15:0];
        end
        if (r < 6 && bound_ports.size() > 0)
            return bound_ports[$urandom_range(0, bound_ports.size() - 1)];
        if (r < 8)
            return 16'($urandom_range(0, 65535));
        if (r == 8) begin
            case ($urandom_range(0, 3))
                0: return 16'd1;
                1: return 16'hFFFF;
                2: return 16'h8000;
                default: return 16'h7FFF;
            endcase
        end
        return 16'd0;
    endfunction

    task automatic send_random_item();
        int          r;
        logic [7:0]  oid;
        logic [15:0] port;
        r    = $urandom_range(0, 99);
        oid  = 8'($urandom_range(0, 255));
        port = pick_port();
        if (r < 25)
            send_request(upta_pkg::FN_ALLOC, 16'd0, oid);
        else if (r < 45)
            send_request(upta_pkg::FN_ALLOC, port, oid);
        else if (r < 65)
            send_request(upta_pkg::FN_LOOKUP, port, oid);
        else if (r < 85)
            send_request(upta_pkg::FN_RELEASE, port, oid);
        else if (r < 95)
            send_request(upta_pkg::t_func'($urandom_range(0, 3)),
                         16'($urandom_range(0, 65535)), oid);
        else
            send_request(upta_pkg::FN_NOP, port, oid);
    endtask

    // Picks a new ephemeral range. Small or empty ranges dominate so that exhaustion
    // shows up and scans stay short. The extremes of both registers come up as well.
    task automatic reprogram_random_range();
        int first;
        int last_end;
        case ($urandom_range(0, 5))
            0: begin
                first    = upta_pkg::RANGE_FIRST_RST;
                last_end = upta_pkg::RANGE_END_RST;
            end
            1: begin
                first    = $urandom_range(1, 65000);
                last_end = first + $urandom_range(1, 40);
            end
            2: begin
                first    = 1;
                last_end = 65536;
            end
            3: begin
                first    = $urandom_range(65500, 65535);
                last_end = 65536;
            end
            4: begin
                first    = $urandom_range(1, 2000);
                last_end = first + $urandom_range(0, 12);
            end
            default: begin
                // Inverted range: nothing can be handed out.
                first    = $urandom_range(2, 65535);
                last_end = $urandom_range(1, first - 1);
            end
        endcase
        program_range(first[15:0], last_end[16:0]);
    endtask

    // Result side: check each accepted beat, then choose the next ready level.
    task automatic check_result();
        t_port_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: status %0d port %0d",
                                      o_status, o_port_out));
            return;
        end
        want = pending_results.pop_front();
        if (o_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d (port %0d)",
                                      o_status, want.status, want.port));
        if (o_port_out !== want.port)
            report_mismatch($sformatf("port_out got %0d expected %0d",
                                      o_port_out, want.port));
        if (o_owner_out !== want.owner)
            report_mismatch($sformatf("owner_out got %0d expected %0d (port %0d)",
                                      o_owner_out, want.owner, want.port));
    endtask

    always @(posedge clk) begin
        if (rst_n && o_valid && rsp_ready)
            check_result();
        if (rx_hold) begin
            rsp_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_stall = pick_gap();
        end
    end

    // The long receiver hold-off is timed here, apart from the test that starts it.
    initial begin
        forever begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Every function code on the reset range. This covers port zero on release and
    // lookup, the table's end ports, an in-use bind and a scan that skips a taken port.
    task automatic test_basic_functions();
        send_request(upta_pkg::FN_LOOKUP, 16'd0, 8'h00);
        send_request(upta_pkg::FN_RELEASE, 16'd0, 8'hFF);
        send_request(upta_pkg::FN_RELEASE, 16'd1234, 8'h00);
        send_request(upta_pkg::FN_ALLOC, 16'hFFFF, 8'hFF);
        send_request(upta_pkg::FN_LOOKUP, 16'hFFFF, 8'h00);
        send_request(upta_pkg::FN_ALLOC, 16'hFFFF, 8'h01);
        send_request(upta_pkg::FN_ALLOC, 16'd1, 8'h00);
        send_request(upta_pkg::FN_LOOKUP, 16'd1, 8'hFF);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h55);
        send_request(upta_pkg::FN_ALLOC, 16'd50001, 8'hAA);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h07);
        send_request(upta_pkg::FN_LOOKUP, 16'd50000, 8'h00);
        send_request(upta_pkg::FN_NOP, 16'hFFFF, 8'hFF);
        send_request(upta_pkg::FN_NOP, 16'd0, 8'h00);
        send_request(upta_pkg::FN_RELEASE, 16'hFFFF, 8'h00);
        send_request(upta_pkg::FN_LOOKUP, 16'hFFFF, 8'h00);
        wait_drained();
    endtask

    // Range edges: a one-port range at the top of the table, an empty range, an
    // inverted range and the lowest possible first port.
    task automatic test_range_limits();
        program_range(16'hFFFF, 17'd65536);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h11);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h22);
        wait_drained();
        program_range(16'd200, 17'd200);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h33);
        wait_drained();
        program_range(16'd300, 17'd299);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h44);
        wait_drained();
        program_range(16'd1, 17'd3);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h66);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h77);
        wait_drained();
        program_range(16'd1, 17'd1);
        send_request(upta_pkg::FN_ALLOC, 16'd0, 8'h88);
        wait_drained();
    endtask

    // Random beats in chunks, with a fresh range and idle pattern before each chunk.
    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 8; chunk++) begin
            reprogram_random_range();
            quiet = ($urandom_range(0, 3) == 0);
            repeat (45) send_random_item();
            wait_drained();
        end
        quiet = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up
    // and stalls its request channel.
    task automatic test_output_backpressure();
        reprogram_random_range();
        -> hold_go;
        repeat (30) send_random_item();
        wait_drained();
    endtask

    // The sender stops until every expected result is back, then resumes.
    task automatic test_sender_pause();
        repeat (10) send_random_item();
        wait_drained();
        repeat (10) send_random_item();
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_functions();
        test_range_limits();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
